// ----- rtl/core/lobm_pkg.sv -----
// lobm_pkg: shared types and codes for the order book matcher
// used by the controller, datapath and top level
package lobm_pkg;

  typedef enum logic [2:0] {
    ST_RESTED    = 3'd0,
    ST_FILLED    = 3'd1,
    ST_MKT_DROP  = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  localparam logic KIND_LIMIT  = 1'b0;
  localparam logic KIND_MARKET = 1'b1;
  localparam logic SIDE_BUY    = 1'b0;
  localparam logic SIDE_SELL   = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture incoming word
    logic scan_start; // reset scan pointer and best tracking
    logic scan_step;  // examine one slot
    logic trade;      // apply trade against best slot
    logic rest;       // write remainder into free slot
    logic emit;       // load output register
    logic emit_trade; // output word is a trade
    logic emit_last;  // output word is last
    logic send;       // present the output register
    logic count_acc;  // bump accepted count
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic    scan_done;
    logic    dup_found;
    logic    best_found;
    logic    best_ok;    // best price within limit, or order is market
    logic    rem_zero;   // remainder zero
    logic    free_found;
    logic    is_market;
    logic    out_busy;
  } sts_t;

endpackage

// ----- rtl/core/lobm_ctrl.sv -----
// lobm_ctrl: sequencing state machine for the order book matcher
// depends on lobm_pkg; drives lobm_dpath by command struct
module lobm_ctrl #(
  parameter int ORDER_SLOTS = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  lobm_pkg::sts_t sts_i,
  output lobm_pkg::cmd_t cmd_o,
  output logic [2:0]     status_o
);
  import lobm_pkg::*;

  localparam int NW = $clog2(ORDER_SLOTS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DUP   = 3'd1;
  localparam logic [2:0] S_BEST  = 3'd2;
  localparam logic [2:0] S_TRADE = 3'd3;
  localparam logic [2:0] S_FREE  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [NW-1:0] ntr_q, ntr_d;
  logic [2:0]    stat_q, stat_d;
  logic          held_q, held_d;

  assign in_stall_o = (state_q != S_IDLE);
  assign status_o   = stat_q;

  always_comb begin
    state_d = state_q;
    ntr_d   = ntr_q;
    stat_d  = stat_q;
    held_d  = held_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load       = 1'b1;
          cmd_o.scan_start = 1'b1;
          ntr_d            = '0;
          held_d           = 1'b0;
          state_d          = S_DUP;
        end
      end
      S_DUP: begin
        if (sts_i.dup_found) begin
          if (!sts_i.out_busy) begin
            stat_d          = ST_DUPLICATE;
            state_d         = S_FIN;
          end
        end else if (sts_i.scan_done) begin
          cmd_o.count_acc  = 1'b1;
          cmd_o.scan_start = 1'b1;
          state_d          = S_BEST;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_BEST: begin
        if (!sts_i.scan_done) begin
          cmd_o.scan_step = 1'b1;
        end else if (sts_i.rem_zero || ntr_q == NW'(ORDER_SLOTS) || !sts_i.best_found ||
                     !sts_i.best_ok) begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_FREE;
        end else begin
          state_d = S_TRADE;
        end
      end
      S_TRADE: begin
        if (held_q) begin
          // earlier trade word is not the last one
          cmd_o.send = 1'b1;
          held_d     = 1'b0;
        end else if (!sts_i.out_busy) begin
          cmd_o.trade      = 1'b1;
          cmd_o.emit       = 1'b1;
          cmd_o.emit_trade = 1'b1;
          held_d           = 1'b1;
          ntr_d            = ntr_q + NW'(1);
          cmd_o.scan_start = 1'b1;
          state_d          = S_BEST;
        end
      end
      S_FREE: begin
        if (sts_i.rem_zero) begin
          stat_d  = ST_FILLED;
          state_d = S_FIN;
        end else if (sts_i.is_market) begin
          stat_d  = ST_MKT_DROP;
          state_d = S_FIN;
        end else if (sts_i.free_found) begin
          cmd_o.rest = 1'b1;
          stat_d     = ST_RESTED;
          state_d    = S_FIN;
        end else if (sts_i.scan_done) begin
          stat_d  = ST_FULL;
          state_d = S_FIN;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_FIN: begin
        if (held_q) begin
          // status rides on the held trade word
          cmd_o.emit_last = 1'b1;
          cmd_o.send      = 1'b1;
          held_d          = 1'b0;
          state_d         = S_IDLE;
        end else if (!sts_i.out_busy) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = 1'b1;
          cmd_o.send      = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ntr_q   <= '0;
      stat_q  <= '0;
      held_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ntr_q   <= ntr_d;
      stat_q  <= stat_d;
      held_q  <= held_d;
    end
  end

endmodule

// ----- rtl/core/lobm_dpath.sv -----
// lobm_dpath: order table, slot scan, trade arithmetic and output register
// depends on lobm_pkg; commanded by lobm_ctrl
module lobm_dpath #(
  parameter int ORDER_SLOTS = 64,
  parameter int PRICE_BITS  = 32,
  parameter int QTY_BITS    = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           order_kind_i,
  input  logic           side_i,
  input  logic [31:0]    order_id_i,
  input  logic [31:0]    limit_price_i,
  input  logic [31:0]    quantity_i,
  input  lobm_pkg::cmd_t cmd_i,
  input  logic [2:0]     status_i,
  output lobm_pkg::sts_t sts_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic           trade_valid_o,
  output logic [31:0]    buy_id_o,
  output logic [31:0]    sell_id_o,
  output logic [31:0]    trade_quantity_o,
  output logic [31:0]    trade_price_o,
  output logic [2:0]     final_status_o,
  output logic           last_o,
  output logic [63:0]    traded_volume_o,
  output logic [31:0]    orders_accepted_o
);
  import lobm_pkg::*;

  localparam int IW = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
  localparam int CW = $clog2(ORDER_SLOTS + 1);

  // per slot tables
  logic [ORDER_SLOTS-1:0]  vld_q;
  logic [ORDER_SLOTS-1:0]  sd_q;
  logic [31:0]             oid_q  [ORDER_SLOTS];
  logic [PRICE_BITS-1:0]   prc_q  [ORDER_SLOTS];
  logic [QTY_BITS-1:0]     rmn_q  [ORDER_SLOTS];
  logic [31:0]             arr_q  [ORDER_SLOTS];

  // incoming order
  logic                  kind_q, side_q;
  logic [31:0]           id_q;
  logic [PRICE_BITS-1:0] lim_q;
  logic [QTY_BITS-1:0]   rem_q;

  // scan
  logic [CW-1:0]         ptr_q;
  logic                  dup_q, bf_q, ff_q;
  logic [IW-1:0]         best_q, free_q;
  logic [PRICE_BITS-1:0] bprc_q;
  logic [31:0]           bage_q;
  logic [QTY_BITS-1:0]   brem_q;
  logic [31:0]           boid_q;
  logic                  rd_v_q;
  logic [IW-1:0]         rd_idx_q;
  logic [31:0]           rd_oid_q;
  logic [PRICE_BITS-1:0] rd_prc_q;
  logic [QTY_BITS-1:0]   rd_rmn_q;
  logic [31:0]           rd_arr_q;
  logic [31:0]           arrc_q;
  logic [63:0]           vol_q;
  logic [31:0]           acc_q;

  logic [IW-1:0]         pi;
  logic                  issue;
  logic [31:0]           age;
  logic                  cand, better;
  logic [QTY_BITS-1:0]   tq;
  logic                  ok;

  // slot read is issued at ptr, compared in the following cycle
  assign pi    = ptr_q[IW-1:0];
  assign issue = cmd_i.scan_step && (ptr_q != CW'(ORDER_SLOTS));
  assign age   = arrc_q - rd_arr_q;
  assign cand  = vld_q[rd_idx_q] && (sd_q[rd_idx_q] != side_q);
  always_comb begin
    if (!bf_q) begin
      better = 1'b1;
    end else if (side_q == SIDE_BUY ? (rd_prc_q < bprc_q) : (rd_prc_q > bprc_q)) begin
      better = 1'b1;
    end else begin
      better = (rd_prc_q == bprc_q) && (age > bage_q);
    end
  end

  assign tq   = (rem_q < brem_q) ? rem_q : brem_q;
  assign ok   = (kind_q == KIND_MARKET) ||
                (side_q == SIDE_BUY ? (bprc_q <= lim_q) : (bprc_q >= lim_q));

  assign sts_o.scan_done      = (ptr_q == CW'(ORDER_SLOTS)) && !rd_v_q;
  assign sts_o.dup_found      = dup_q;
  assign sts_o.best_found     = bf_q;
  assign sts_o.best_ok        = ok;
  assign sts_o.rem_zero       = (rem_q == '0);
  assign sts_o.free_found     = ff_q;
  assign sts_o.is_market      = (kind_q == KIND_MARKET);
  assign sts_o.out_busy       = out_valid_o && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      arrc_q      <= '0;
      vol_q       <= '0;
      acc_q       <= '0;
      ptr_q       <= '0;
      rd_v_q      <= 1'b0;
      dup_q       <= 1'b0;
      bf_q        <= 1'b0;
      ff_q        <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (cmd_i.send) out_valid_o <= 1'b1;
      else if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
      if (cmd_i.scan_start) begin
        ptr_q  <= '0;
        rd_v_q <= 1'b0;
        dup_q  <= 1'b0;
        bf_q   <= 1'b0;
        ff_q   <= 1'b0;
      end else begin
        rd_v_q <= issue;
        if (issue) begin
          ptr_q <= ptr_q + CW'(1);
          if (!vld_q[pi]) ff_q <= 1'b1;
        end
        if (rd_v_q) begin
          if (vld_q[rd_idx_q] && rd_oid_q == id_q) dup_q <= 1'b1;
          if (cand && better) bf_q <= 1'b1;
        end
      end
      if (cmd_i.count_acc) acc_q <= acc_q + 32'd1;
      if (cmd_i.trade) begin
        vol_q <= vol_q + 64'(tq);
        if (brem_q == tq) vld_q[best_q] <= 1'b0;
      end
      if (cmd_i.rest) begin
        vld_q[free_q] <= 1'b1;
        arrc_q        <= arrc_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= order_kind_i;
      side_q <= side_i;
      id_q   <= order_id_i;
      lim_q  <= PRICE_BITS'(limit_price_i);
      rem_q  <= QTY_BITS'(quantity_i);
    end
    if (issue) begin
      rd_idx_q <= pi;
      rd_oid_q <= oid_q[pi];
      rd_prc_q <= prc_q[pi];
      rd_rmn_q <= rmn_q[pi];
      rd_arr_q <= arr_q[pi];
      if (!vld_q[pi] && !ff_q) free_q <= pi;
    end
    if (rd_v_q && !cmd_i.scan_start && cand && better) begin
      best_q <= rd_idx_q;
      bprc_q <= rd_prc_q;
      bage_q <= age;
      brem_q <= rd_rmn_q;
      boid_q <= rd_oid_q;
    end
    if (cmd_i.trade) begin
      rem_q          <= rem_q - tq;
      rmn_q[best_q]  <= brem_q - tq;
    end
    if (cmd_i.rest) begin
      sd_q[free_q]  <= side_q;
      oid_q[free_q] <= id_q;
      prc_q[free_q] <= lim_q;
      rmn_q[free_q] <= rem_q;
      arr_q[free_q] <= arrc_q;
    end
    if (cmd_i.emit) begin
      trade_valid_o    <= cmd_i.emit_trade;
      last_o           <= cmd_i.emit_last;
      final_status_o   <= cmd_i.emit_last ? status_i : 3'd0;
      orders_accepted_o <= acc_q;
      if (cmd_i.emit_trade) begin
        buy_id_o         <= (side_q == SIDE_BUY) ? id_q : boid_q;
        sell_id_o        <= (side_q == SIDE_BUY) ? boid_q : id_q;
        trade_quantity_o <= 32'(tq);
        trade_price_o    <= 32'(bprc_q);
        traded_volume_o  <= vol_q + 64'(tq);
      end else begin
        buy_id_o         <= '0;
        sell_id_o        <= '0;
        trade_quantity_o <= '0;
        trade_price_o    <= '0;
        traded_volume_o  <= vol_q;
      end
    end else if (cmd_i.emit_last) begin
      // fold final status onto the held last trade word
      final_status_o <= status_i;
      last_o         <= 1'b1;
    end
  end

endmodule

// ----- rtl/core/limit_order_book_matcher.sv -----
// limit_order_book_matcher: price-time priority order book, one order at a time
// a table scan reads one slot per cycle
// an accepted order without trades runs a duplicate scan, a best scan and, if
// it is a limit order, a free slot search; each trade adds another best scan
// throughput: next order accepted the cycle after the final word is queued
// reset: asynchronous active low, clears valid bits, counters and control
module limit_order_book_matcher #(
  parameter int ORDER_SLOTS = 64,
  parameter int PRICE_BITS  = 32,
  parameter int QTY_BITS    = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        order_kind_i,
  input  logic        side_i,
  input  logic [31:0] order_id_i,
  input  logic [31:0] limit_price_i,
  input  logic [31:0] quantity_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        trade_valid_o,
  output logic [31:0] buy_id_o,
  output logic [31:0] sell_id_o,
  output logic [31:0] trade_quantity_o,
  output logic [31:0] trade_price_o,
  output logic [2:0]  final_status_o,
  output logic        last_o,
  output logic [63:0] traded_volume_o,
  output logic [31:0] orders_accepted_o
);
  import lobm_pkg::*;

  cmd_t       cmd;
  sts_t       sts;
  logic [2:0] status;

  lobm_ctrl #(.ORDER_SLOTS(ORDER_SLOTS)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .sts_i(sts), .cmd_o(cmd), .status_o(status)
  );

  lobm_dpath #(
    .ORDER_SLOTS(ORDER_SLOTS), .PRICE_BITS(PRICE_BITS), .QTY_BITS(QTY_BITS)
  ) u_dpath (
    .clk_i, .rst_ni, .order_kind_i, .side_i, .order_id_i, .limit_price_i,
    .quantity_i, .cmd_i(cmd), .status_i(status), .sts_o(sts),
    .out_valid_o, .out_stall_i, .trade_valid_o, .buy_id_o, .sell_id_o,
    .trade_quantity_o, .trade_price_o, .final_status_o, .last_o,
    .traded_volume_o, .orders_accepted_o
  );

endmodule
